/* rtl/core/sca_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sca_pkg
// Shared types and constants of the all-pairs sphere collision block.
// ----------------------------------------------------------------------------
package sca_pkg;

    localparam int MaxSpheresDefault = 64;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } op_code_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_TEST,
        ST_DECIDE,
        ST_EMIT_RD,
        ST_EMIT_RD2,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [30:0] base_radius;
        logic [31:0] scale_x;
        logic [31:0] scale_y;
        logic [31:0] scale_z;
        logic [15:0] collider_type;
        logic [15:0] collide_mask;
        logic [15:0] entity_id;
        logic        operation;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  slot_index;
        logic        is_hit;
        logic [15:0] partner_type;
        logic [15:0] partner_entity;
        logic        last;
    } out_item_t;

endpackage : sca_pkg
`default_nettype wire

/* rtl/core/sca_stream_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sca_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface sca_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface : sca_stream_if
`default_nettype wire

/* rtl/core/sca_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sca_datapath
// Sphere memories, the world radius unit, the pair test pipeline and the
// per-sphere hit state.
// ----------------------------------------------------------------------------
module sca_datapath #(
    parameter int MAX_SPHERES = sca_pkg::MaxSpheresDefault,
    parameter int IW = $clog2(MAX_SPHERES)
) (
    input  wire logic             clk,
    input  wire sca_pkg::in_item_t in_item,
    input  wire logic             load_en,
    input  wire logic [IW-1:0]    load_idx,
    input  wire logic [IW-1:0]    idx_a,
    input  wire logic [IW-1:0]    idx_b,
    input  wire logic             fetch_en,
    input  wire logic             test_en,
    input  wire logic             decide_en,
    input  wire logic             clear_en,
    input  wire logic [IW-1:0]    clear_idx,
    input  wire logic             emit_rd_en,
    input  wire logic [IW-1:0]    emit_idx,
    input  wire logic             emit_rd2_en,
    output logic                  emit_hit,
    output logic [15:0]           emit_type,
    output logic [15:0]           emit_entity
);
    import sca_pkg::*;

    localparam int N = MAX_SPHERES;

    logic [31:0] cx_mem [N];
    logic [31:0] cy_mem [N];
    logic [31:0] cz_mem [N];
    logic [31:0] rad_mem [N];
    logic [15:0] typ_mem [N];
    logic [15:0] msk_mem [N];
    logic [15:0] ent_mem [N];
    logic [15:0] typb_mem [N];
    logic [15:0] entb_mem [N];
    logic        hit_mem [N];
    logic [IW-1:0] par_mem [N];

    // World radius: largest magnitude scale times radius, saturated.
    logic [32:0] abs_x, abs_y, abs_z, smax;
    logic [63:0] prod;
    logic [31:0] wrad;
    always_comb
    begin
        abs_x = in_item.scale_x[31] ? 33'(-{1'b1, in_item.scale_x}) : {1'b0, in_item.scale_x};
        abs_y = in_item.scale_y[31] ? 33'(-{1'b1, in_item.scale_y}) : {1'b0, in_item.scale_y};
        abs_z = in_item.scale_z[31] ? 33'(-{1'b1, in_item.scale_z}) : {1'b0, in_item.scale_z};
        smax = abs_x;
        if (abs_y > smax) smax = abs_y;
        if (abs_z > smax) smax = abs_z;
        prod = 64'({33'd0, in_item.base_radius} * {31'd0, smax});
        wrad = (prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod[47:16];
    end

    // Load writes.
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            cx_mem[load_idx]  <= in_item.pos_x;
            cy_mem[load_idx]  <= in_item.pos_y;
            cz_mem[load_idx]  <= in_item.pos_z;
            rad_mem[load_idx] <= wrad;
            typ_mem[load_idx] <= in_item.collider_type;
            msk_mem[load_idx] <= in_item.collide_mask;
            ent_mem[load_idx] <= in_item.entity_id;
            typb_mem[load_idx] <= in_item.collider_type;
            entb_mem[load_idx] <= in_item.entity_id;
        end
    end

    // Fetch stage: registered reads of both spheres.
    logic signed [31:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic [31:0] ar_reg, br_reg;
    logic [15:0] at_reg, am_reg, bt_reg, bm_reg;
    always_ff @(posedge clk)
    begin
        if (fetch_en)
        begin
            ax_reg <= cx_mem[idx_a]; ay_reg <= cy_mem[idx_a]; az_reg <= cz_mem[idx_a];
            bx_reg <= cx_mem[idx_b]; by_reg <= cy_mem[idx_b]; bz_reg <= cz_mem[idx_b];
            ar_reg <= rad_mem[idx_a]; br_reg <= rad_mem[idx_b];
            at_reg <= typ_mem[idx_a]; am_reg <= msk_mem[idx_a];
            bt_reg <= typ_mem[idx_b]; bm_reg <= msk_mem[idx_b];
        end
    end

    // Test stage: squares of differences and of the radius sum, and the mask check.
    logic [32:0] dx, dy, dz, rs;
    logic [65:0] sqx_reg, sqy_reg, sqz_reg, sqr_reg;
    logic        elig_reg;
    always_comb
    begin
        dx = 33'($signed({ax_reg[31], ax_reg}) - $signed({bx_reg[31], bx_reg}));
        dy = 33'($signed({ay_reg[31], ay_reg}) - $signed({by_reg[31], by_reg}));
        dz = 33'($signed({az_reg[31], az_reg}) - $signed({bz_reg[31], bz_reg}));
        if (dx[32]) dx = 33'(-dx);
        if (dy[32]) dy = 33'(-dy);
        if (dz[32]) dz = 33'(-dz);
        rs = {1'b0, ar_reg} + {1'b0, br_reg};
    end
    always_ff @(posedge clk)
    begin
        if (test_en)
        begin
            sqx_reg  <= dx * dx;
            sqy_reg  <= dy * dy;
            sqz_reg  <= dz * dz;
            sqr_reg  <= rs * rs;
            elig_reg <= ((at_reg & bm_reg) != 16'd0) && ((bt_reg & am_reg) != 16'd0);
        end
    end

    // Decide stage: compare and update hit state of both spheres.
    logic [67:0] dsum;
    logic        hit_pair;
    always_comb
    begin
        dsum = 68'(sqx_reg) + 68'(sqy_reg) + 68'(sqz_reg);
        hit_pair = elig_reg && (dsum <= 68'(sqr_reg));
    end

    // Pairs arrive in ascending order of both indexes, so the latest hit is
    // always the highest partner.
    always_ff @(posedge clk)
    begin
        if (clear_en)
        begin
            hit_mem[clear_idx] <= 1'b0;
            par_mem[clear_idx] <= '0;
        end
        else if (decide_en && hit_pair)
        begin
            hit_mem[idx_a] <= 1'b1;
            hit_mem[idx_b] <= 1'b1;
            par_mem[idx_a] <= idx_b;
            par_mem[idx_b] <= idx_a;
        end
    end

    // Result reads: flag and partner index, then partner fields.
    logic          ehit_reg;
    logic [IW-1:0] epar_reg;
    always_ff @(posedge clk)
    begin
        if (emit_rd_en)
        begin
            ehit_reg <= hit_mem[emit_idx];
            epar_reg <= par_mem[emit_idx];
        end
        if (emit_rd2_en)
        begin
            emit_hit    <= ehit_reg;
            emit_type   <= ehit_reg ? typb_mem[epar_reg] : 16'd0;
            emit_entity <= ehit_reg ? entb_mem[epar_reg] : 16'd0;
        end
    end

endmodule : sca_datapath
`default_nettype wire

/* rtl/core/sca_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sca_ctrl
// Sequencer: load slots, clear pass, pair walk and result emission.
// ----------------------------------------------------------------------------
module sca_ctrl #(
    parameter int MAX_SPHERES = sca_pkg::MaxSpheresDefault,
    parameter int IW = $clog2(MAX_SPHERES)
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_op,
    output logic               in_ready,
    input  wire logic          out_ready,
    output logic               out_valid,
    output logic [IW-1:0]      out_idx,
    output logic               out_last,
    output logic               load_en,
    output logic [IW-1:0]      load_idx,
    output logic [IW-1:0]      idx_a,
    output logic [IW-1:0]      idx_b,
    output logic               fetch_en,
    output logic               test_en,
    output logic               decide_en,
    output logic               clear_en,
    output logic [IW-1:0]      clear_idx,
    output logic               emit_rd_en,
    output logic [IW-1:0]      emit_idx,
    output logic               emit_rd2_en
);
    import sca_pkg::*;

    localparam int CW = IW + 1;
    localparam logic [CW-1:0] NMAX = CW'(MAX_SPHERES);

    ctrl_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [IW-1:0] a_reg, a_next, b_reg, b_next;
    logic          valid_reg, valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            valid_reg <= valid_next;
        end
    end

    logic [CW-1:0] b_inc, a_inc;
    always_comb
    begin
        a_inc = CW'(a_reg) + CW'(1);
        b_inc = CW'(b_reg) + CW'(1);
        state_next = state_reg;
        count_next = count_reg;
        a_next = a_reg;
        b_next = b_reg;
        valid_next = valid_reg;
        in_ready = 1'b0;
        load_en = 1'b0;
        load_idx = count_reg[IW-1:0];
        idx_a = a_reg;
        idx_b = b_reg;
        fetch_en = 1'b0;
        test_en = 1'b0;
        decide_en = 1'b0;
        clear_en = 1'b0;
        clear_idx = a_reg;
        emit_rd_en = 1'b0;
        emit_idx = a_reg;
        emit_rd2_en = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_COMPUTE)
                    begin
                        if (count_reg != '0)
                        begin
                            a_next = '0;
                            state_next = ST_CLEAR;
                        end
                    end
                    else if (count_reg != NMAX)
                    begin
                        load_en = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            ST_CLEAR:
            begin
                clear_en = 1'b1;
                if (a_inc == count_reg)
                begin
                    a_next = '0;
                    b_next = IW'(1);
                    state_next = (count_reg == CW'(1)) ? ST_EMIT_RD : ST_FETCH;
                end
                else
                    a_next = a_inc[IW-1:0];
            end
            ST_FETCH:
            begin
                fetch_en = 1'b1;
                state_next = ST_TEST;
            end
            ST_TEST:
            begin
                test_en = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                decide_en = 1'b1;
                state_next = ST_FETCH;
                if (b_inc != count_reg)
                    b_next = b_inc[IW-1:0];
                else if (a_inc + CW'(1) != count_reg)
                begin
                    a_next = a_inc[IW-1:0];
                    b_next = IW'(a_inc + CW'(1));
                end
                else
                begin
                    a_next = '0;
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD:
            begin
                emit_rd_en = 1'b1;
                state_next = ST_EMIT_RD2;
            end
            ST_EMIT_RD2:
            begin
                emit_rd2_en = 1'b1;
                valid_next = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_ready)
                begin
                    valid_next = 1'b0;
                    if (a_inc == count_reg)
                    begin
                        a_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        a_next = a_inc[IW-1:0];
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid = valid_reg;
    assign out_idx   = a_reg;
    assign out_last  = (a_inc == count_reg);

endmodule : sca_ctrl
`default_nettype wire

/* rtl/core/sphere_collision_all_pairs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_collision_all_pairs
// A compute clears every loaded slot, walks each unordered pair through
// fetch, multiply and compare, then reads and emits each result, holding
// on any output stall. One sequencer walks one pair at a time. Reset
// empties the bank; sphere data is undefined until loaded.
// ----------------------------------------------------------------------------
module sphere_collision_all_pairs #(
    parameter int MAX_SPHERES = sca_pkg::MaxSpheresDefault
) (
    input  wire logic clk,
    input  wire logic rst_n,
    sca_stream_if.sink   in_ch,
    sca_stream_if.source out_ch
);
    import sca_pkg::*;

    localparam int IW = $clog2(MAX_SPHERES);

    logic load_en, fetch_en, test_en, decide_en, clear_en, emit_rd_en, emit_rd2_en;
    logic [IW-1:0] load_idx, idx_a, idx_b, clear_idx, emit_idx, out_idx;
    logic out_last, emit_hit;
    logic [15:0] emit_type, emit_entity;
    in_item_t item;

    assign item = in_ch.payload;

    sca_ctrl #(.MAX_SPHERES(MAX_SPHERES), .IW(IW)) u_ctrl (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_op(item.operation), .in_ready(in_ch.ready),
        .out_ready(out_ch.ready), .out_valid(out_ch.valid),
        .out_idx, .out_last,
        .load_en, .load_idx, .idx_a, .idx_b, .fetch_en, .test_en, .decide_en,
        .clear_en, .clear_idx, .emit_rd_en, .emit_idx, .emit_rd2_en
    );

    sca_datapath #(.MAX_SPHERES(MAX_SPHERES), .IW(IW)) u_dp (
        .clk, .in_item(item),
        .load_en, .load_idx, .idx_a, .idx_b, .fetch_en, .test_en, .decide_en,
        .clear_en, .clear_idx, .emit_rd_en, .emit_idx, .emit_rd2_en,
        .emit_hit, .emit_type, .emit_entity
    );

    // Result transaction payload.
    always_comb
    begin
        out_ch.payload.slot_index     = 6'(out_idx);
        out_ch.payload.is_hit         = emit_hit;
        out_ch.payload.partner_type   = emit_type;
        out_ch.payload.partner_entity = emit_entity;
        out_ch.payload.last           = out_last;
    end

endmodule : sphere_collision_all_pairs
`default_nettype wire

/* bench/sphere_collision_all_pairs_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_collision_all_pairs_test
// Self-checking bench for the all-pairs sphere collision block. Spheres are
// loaded and pair tests are run through the valid/ready channels. A local
// copy of the sphere bank predicts every per-sphere report.
// ----------------------------------------------------------------------------
module sphere_collision_all_pairs_test;
    import sca_pkg::*;

    localparam int Slots      = 64;
    localparam int CycleLimit = 20000000;
    localparam int TailCycles = 400;

    logic clk;
    logic rst_n;

    sca_stream_if #(.payload_t(in_item_t))  in_ch ();
    sca_stream_if #(.payload_t(out_item_t)) out_ch ();

    sphere_collision_all_pairs dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Local copy of the sphere bank.
    logic signed [31:0] bank_centre [Slots][3];
    logic [31:0]        bank_radius [Slots];
    logic [15:0]        bank_type   [Slots];
    logic [15:0]        bank_mask   [Slots];
    logic [15:0]        bank_entity [Slots];
    int                 bank_count;

    out_item_t expected_reports [$];

    int  mismatch_count;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    int  hold_length;
    bit  hold_toggle;
    bit  hold_seen;
    int  hold_left;
    longint cycle_count;

    // Clock and timeout.
    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver readiness, with random stalls and long hold-offs on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_seen    <= 1'b0;
        end
        else if (hold_toggle != hold_seen)
        begin
            hold_seen    <= hold_toggle;
            hold_left    <= hold_length;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // World radius: largest absolute scale times the base radius, saturated.
    function automatic logic [31:0] world_radius(in_item_t it);
        logic [32:0] mag_x, mag_y, mag_z, big;
        logic [63:0] prod;
        mag_x = it.scale_x[31] ? -{1'b1, it.scale_x} : {1'b0, it.scale_x};
        mag_y = it.scale_y[31] ? -{1'b1, it.scale_y} : {1'b0, it.scale_y};
        mag_z = it.scale_z[31] ? -{1'b1, it.scale_z} : {1'b0, it.scale_z};
        big = mag_x;
        if (mag_y > big) big = mag_y;
        if (mag_z > big) big = mag_z;
        prod = ({33'd0, it.base_radius} * {31'd0, big}) >> 16;
        return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
    endfunction

    // Exact overlap test of two banked spheres at full width.
    function automatic bit spheres_touch(int a, int b);
        logic signed [32:0] diff;
        logic [32:0]        mag;
        logic [127:0]       dist_sq, reach_sq;
        logic [32:0]        reach;
        dist_sq = '0;
        for (int k = 0; k < 3; k++)
        begin
            diff = {bank_centre[a][k][31], bank_centre[a][k]}
                 - {bank_centre[b][k][31], bank_centre[b][k]};
            mag = diff[32] ? -diff : diff;
            dist_sq = dist_sq + ({95'd0, mag} * {95'd0, mag});
        end
        reach = {1'b0, bank_radius[a]} + {1'b0, bank_radius[b]};
        reach_sq = {95'd0, reach} * {95'd0, reach};
        return dist_sq <= reach_sq;
    endfunction

    // Update the bank on an accepted transaction and queue the reports.
    task automatic predict_collisions(in_item_t it);
        bit hit      [Slots];
        int partner  [Slots];
        out_item_t r;
        if (it.operation == logic'(OP_LOAD))
        begin
            if (bank_count < Slots)
            begin
                bank_centre[bank_count][0] = it.pos_x;
                bank_centre[bank_count][1] = it.pos_y;
                bank_centre[bank_count][2] = it.pos_z;
                bank_radius[bank_count]    = world_radius(it);
                bank_type[bank_count]      = it.collider_type;
                bank_mask[bank_count]      = it.collide_mask;
                bank_entity[bank_count]    = it.entity_id;
                bank_count++;
            end
        end
        else
        begin
            for (int i = 0; i < bank_count; i++)
            begin
                hit[i]     = 1'b0;
                partner[i] = 0;
            end
            for (int i = 0; i < bank_count; i++)
            begin
                for (int j = i + 1; j < bank_count; j++)
                begin
                    if ((bank_type[i] & bank_mask[j]) == 0 ||
                        (bank_type[j] & bank_mask[i]) == 0)
                        continue;
                    if (!spheres_touch(i, j))
                        continue;
                    if (!hit[i] || j > partner[i]) partner[i] = j;
                    if (!hit[j] || i > partner[j]) partner[j] = i;
                    hit[i] = 1'b1;
                    hit[j] = 1'b1;
                end
            end
            for (int i = 0; i < bank_count; i++)
            begin
                r.slot_index     = i[5:0];
                r.is_hit         = hit[i];
                r.partner_type   = hit[i] ? bank_type[partner[i]] : 16'd0;
                r.partner_entity = hit[i] ? bank_entity[partner[i]] : 16'd0;
                r.last           = (i + 1 == bank_count);
                expected_reports.push_back(r);
            end
        end
    endtask

    // Compare each accepted report with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected report: slot %0d", out_ch.payload.slot_index);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (want != out_ch.payload)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("Report mismatch: expected slot %0d hit %0d type %h ent %h last %0d",
                                 want.slot_index, want.is_hit, want.partner_type,
                                 want.partner_entity, want.last);
                        $display("                 got slot %0d hit %0d type %h ent %h last %0d",
                                 out_ch.payload.slot_index, out_ch.payload.is_hit,
                                 out_ch.payload.partner_type,
                                 out_ch.payload.partner_entity, out_ch.payload.last);
                    end
                end
            end
        end
    end

    // Offer one transaction, with random idle cycles ahead of it.
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= it;
        do @(posedge clk); while (!in_ch.ready);
        predict_collisions(it);
    endtask

    // Stop offering and wait until every report has come back.
    task automatic drain_reports();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);
    endtask

    function automatic in_item_t make_sphere(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [31:0] z, logic [30:0] rad,
                                             logic signed [31:0] scl, logic [15:0] ctype,
                                             logic [15:0] cmask, logic [15:0] ent);
        in_item_t it;
        it = '0;
        it.operation     = logic'(OP_LOAD);
        it.pos_x         = x;
        it.pos_y         = y;
        it.pos_z         = z;
        it.base_radius   = rad;
        it.scale_x       = scl;
        it.scale_y       = scl;
        it.scale_z       = scl;
        it.collider_type = ctype;
        it.collide_mask  = cmask;
        it.entity_id     = ent;
        return it;
    endfunction

    function automatic in_item_t compute_item();
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom});
        it.operation = logic'(OP_COMPUTE);
        return it;
    endfunction

    // Random sphere, clustered so that many pairs overlap.
    function automatic in_item_t random_sphere();
        in_item_t it;
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom});
        it.operation = logic'(OP_LOAD);
        if ($urandom_range(7) != 0)
        begin
            it.pos_x       = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            it.pos_y       = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            it.pos_z       = $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
            it.base_radius = 31'($urandom_range(32'h000C_0000));
            it.scale_x     = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
            it.scale_y     = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
            it.scale_z     = $signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
        end
        if ($urandom_range(3) != 0)
        begin
            it.collider_type = 16'd1 << $urandom_range(2);
            it.collide_mask  = it.collide_mask | 16'h0007;
        end
        return it;
    endfunction

    // A compute with an empty bank must produce nothing.
    task automatic test_empty_bank();
        send_item(compute_item());
        drain_reports();
    endtask

    // Field extremes, saturation, mask filtering and exact contact.
    task automatic test_extremes();
        send_item(make_sphere(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                              31'h7FFF_FFFF, 32'sh8000_0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_sphere(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                              31'h7FFF_FFFF, 32'sh7FFF_FFFF, 16'h8000, 16'hFFFF, 16'h0001));
        // Same place, but the type meets no mask, then no mask at all.
        send_item(make_sphere(32'sh0, 32'sh0, 32'sh0, 31'h7FFF_FFFF, 32'sh8000_0000,
                              16'h0000, 16'hFFFF, 16'h1234));
        send_item(make_sphere(32'sh0, 32'sh0, 32'sh0, 31'h7FFF_FFFF, 32'sh8000_0000,
                              16'hFFFF, 16'h0000, 16'h4321));
        // Two points of zero radius at one place overlap.
        send_item(make_sphere(32'sh5_0000, 32'sh5_0000, 32'sh5_0000, 31'h0,
                              32'sh0, 16'h0100, 16'h0100, 16'h00A0));
        send_item(make_sphere(32'sh5_0000, 32'sh5_0000, 32'sh5_0000, 31'h1_0000,
                              32'sh0, 16'h0100, 16'h0100, 16'h00A1));
        // Unit spheres exactly touching, then one step apart.
        send_item(make_sphere(32'sh40_0000, 32'sh0, 32'sh0, 31'h1_0000, 32'sh1_0000,
                              16'h0200, 16'h0200, 16'h00B0));
        send_item(make_sphere(32'sh40_0000, 32'sh2_0000, 32'sh0, 31'h1_0000,
                              -32'sh1_0000, 16'h0200, 16'h0200, 16'h00B1));
        send_item(make_sphere(32'sh80_0000, 32'sh0, 32'sh0, 31'h1_0000, 32'sh1_0000,
                              16'h0400, 16'h0400, 16'h00C0));
        send_item(make_sphere(32'sh80_0000, 32'sh2_0001, 32'sh0, 31'h1_0000,
                              32'sh1_0000, 16'h0400, 16'h0400, 16'h00C1));
        send_item(compute_item());
        // A second compute must give the same reports.
        send_item(compute_item());
        drain_reports();
    endtask

    // Mostly pair tests over a slowly growing bank.
    task automatic test_random(int count, int idle_pct, int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 22)
                send_item(random_sphere());
            else
                send_item(compute_item());
        end
        drain_reports();
    endtask

    // Long receiver hold-off while loads keep coming, so the input stalls.
    task automatic test_backpressure();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(random_sphere());
        hold_length = 3000;
        hold_toggle = ~hold_toggle;
        send_item(compute_item());
        for (int n = 0; n < 6; n++)
            send_item(random_sphere());
        send_item(compute_item());
        drain_reports();
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.payload      = '0;
        cycle_count        = 0;
        mismatch_count     = 0;
        bank_count         = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_length        = 0;
        hold_toggle        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_bank();
        test_extremes();
        test_backpressure();
        test_random(95, 0, 0);
        test_random(95, 57, 0);
        test_random(95, 0, 57);
        test_random(95, 16, 16);

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
